[sv/trbi_pkg.sv]
// ----------------------------------------------------------------------------
// trbi_pkg
// Shared constants, codes and item types of the timecoded ring buffer index.
// ----------------------------------------------------------------------------
package trbi_pkg;

  // ring geometry, fixed by the slot field width
  localparam int MAX_SLOTS   = 1024;
  localparam int SLOT_W      = 10;
  localparam int COUNT_W     = 11;

  // record alignment (power of two)
  localparam int ALIGN_BYTES = 4096;
  localparam int ALIGN_LOG2  = 12;

  // field widths
  localparam int TC_W        = 31;
  localparam int LEN_W       = 25;
  localparam int OFFSET_W    = 34;

  // configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // largest record size and largest timecode
  localparam logic [LEN_W-1:0] REC_MAX = LEN_W'(16777216);
  localparam logic [TC_W-1:0]  TC_MAX  = {TC_W{1'b1}};

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_t;

  typedef enum logic {
    REG_RECORD_BYTES = 1'b0,
    REG_SLOT_COUNT   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t              op;
    logic [LEN_W-1:0] length;
    logic [TC_W-1:0]  timecode;
  } in_item_t;

  typedef struct packed {
    logic                ok;
    logic [TC_W-1:0]     record_timecode;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] byte_offset;
    logic [LEN_W-1:0]    copy_length;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    op_t               op;
    logic              pre_ok;
    logic [TC_W-1:0]   tc;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  // one entry of the slot store
  typedef struct packed {
    logic [TC_W-1:0]  tc;
    logic [LEN_W-1:0] len;
  } slot_entry_t;

endpackage

[sv/trbi_stream_if.sv]
// ----------------------------------------------------------------------------
// trbi_stream_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface trbi_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/trbi_ram.sv]
// ----------------------------------------------------------------------------
// trbi_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module trbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, or read into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[sv/trbi_front.sv]
// ----------------------------------------------------------------------------
// trbi_front
// Accepts items, keeps the ring pointers and classifies each put or get.
// ----------------------------------------------------------------------------
module trbi_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  trbi_pkg::in_item_t            in_item,
  output logic                          in_ready,
  input  logic [trbi_pkg::COUNT_W-1:0]  slot_count,
  input  logic                          q_full,
  output logic                          push,
  output trbi_pkg::cmd_t                cmd
);

  localparam int SLOT_W  = trbi_pkg::SLOT_W;
  localparam int COUNT_W = trbi_pkg::COUNT_W;
  localparam int TC_W    = trbi_pkg::TC_W;

  logic                empty_r,   empty_nxt;
  logic [TC_W-1:0]     newest_r,  newest_nxt;
  logic [SLOT_W-1:0]   ws_r,      ws_nxt;
  logic [SLOT_W-1:0]   hi_r,      hi_nxt;
  logic                wrapped_r, wrapped_nxt;

  logic                accept;
  logic                is_put;
  logic [COUNT_W-1:0]  n;
  logic [COUNT_W-1:0]  ws_inc;
  logic [SLOT_W-1:0]   put_slot;
  logic [TC_W-1:0]     put_tc;
  logic                refused;
  logic [TC_W-1:0]     diff;
  logic                in_window;
  logic [SLOT_W+1:0]   s_sub;
  logic [SLOT_W+1:0]   s_wrap;
  logic [SLOT_W-1:0]   get_slot;
  logic                get_valid;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;
  assign is_put   = (in_item.op == trbi_pkg::OP_PUT);

  // slot count in use, clamped to one..max
  always_comb begin
    if (slot_count == '0) begin
      n = COUNT_W'(1);
    end else if (slot_count > COUNT_W'(trbi_pkg::MAX_SLOTS)) begin
      n = COUNT_W'(trbi_pkg::MAX_SLOTS);
    end else begin
      n = slot_count;
    end
  end

  // put: next write slot and timecode
  assign ws_inc   = {1'b0, ws_r} + COUNT_W'(1);
  assign put_slot = (ws_inc >= n) ? '0 : ws_inc[SLOT_W-1:0];
  assign refused  = !empty_r && (newest_r == trbi_pkg::TC_MAX);
  assign put_tc   = empty_r ? '0 : newest_r + TC_W'(1);

  // get: window check and slot lookup by stepping back from the write slot
  assign diff      = newest_r - in_item.timecode;
  assign in_window = !empty_r && (in_item.timecode <= newest_r) &&
                     (diff <= TC_W'(n));
  assign s_sub     = {2'b00, ws_r} - {1'b0, diff[COUNT_W-1:0]};
  assign s_wrap    = s_sub[SLOT_W+1] ? s_sub + {1'b0, n} : s_sub;
  assign get_slot  = s_wrap[SLOT_W-1:0];

  // written slots are one up to the high mark, and slot zero once wrapped
  assign get_valid = (get_slot == '0) ? wrapped_r : (get_slot <= hi_r);

  // classified command
  always_comb begin
    cmd.op  = in_item.op;
    cmd.len = in_item.length;
    if (is_put) begin
      cmd.pre_ok = !refused;
      cmd.tc     = put_tc;
      cmd.slot   = put_slot;
    end else begin
      cmd.pre_ok = in_window && get_valid;
      cmd.tc     = in_item.timecode;
      cmd.slot   = get_slot;
    end
  end

  // ring state update on an accepted put
  always_comb begin
    empty_nxt   = empty_r;
    newest_nxt  = newest_r;
    ws_nxt      = ws_r;
    hi_nxt      = hi_r;
    wrapped_nxt = wrapped_r;
    if (accept && is_put && !refused) begin
      empty_nxt  = 1'b0;
      newest_nxt = put_tc;
      ws_nxt     = put_slot;
      if (put_slot == '0) begin
        wrapped_nxt = 1'b1;
      end else if (put_slot > hi_r) begin
        hi_nxt = put_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_r   <= 1'b1;
      newest_r  <= '0;
      ws_r      <= '0;
      hi_r      <= '0;
      wrapped_r <= 1'b0;
    end else begin
      empty_r   <= empty_nxt;
      newest_r  <= newest_nxt;
      ws_r      <= ws_nxt;
      hi_r      <= hi_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

  // a successful put leaves the ring non-empty
  a_put_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_put && !refused |=> !empty_r)
    else $error("ring still empty after a put");

  // while the ring is non-empty, the current write slot always counts as written
  a_ws_written: assert property (@(posedge clk) disable iff (!rst_n)
    !empty_r |-> ((ws_r == '0 && wrapped_r) || (ws_r != '0 && ws_r <= hi_r)))
    else $error("write slot outside the written range");

endmodule

[sv/trbi_queue.sv]
// ----------------------------------------------------------------------------
// trbi_queue
// Short command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module trbi_queue #(
  parameter int DEPTH = trbi_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  trbi_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output trbi_pkg::cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  trbi_pkg::cmd_t   entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entries_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != CNT_W'(DEPTH))
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("command popped from an empty queue");

endmodule

[sv/trbi_back.sv]
// ----------------------------------------------------------------------------
// trbi_back
// Carries out commands on the slot store and builds the result items.
// ----------------------------------------------------------------------------
module trbi_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  trbi_pkg::cmd_t               q_cmd,
  output logic                         pop,
  input  logic [trbi_pkg::LEN_W-1:0]   record_bytes,
  output logic                         out_valid,
  output trbi_pkg::out_item_t          out_item,
  input  logic                         out_ready
);

  localparam int SLOT_W   = trbi_pkg::SLOT_W;
  localparam int LEN_W    = trbi_pkg::LEN_W;
  localparam int OFFSET_W = trbi_pkg::OFFSET_W;
  localparam int ENTRY_W  = $bits(trbi_pkg::slot_entry_t);

  logic                  b_busy_r,  b_busy_nxt;
  trbi_pkg::cmd_t        b_cmd_r;
  logic                  out_valid_r, out_valid_nxt;
  trbi_pkg::out_item_t   out_item_r;

  logic                  out_free;
  logic                  b_done;
  logic                  ram_en;
  logic                  ram_we;
  trbi_pkg::slot_entry_t wr_entry;
  trbi_pkg::slot_entry_t rd_entry;
  logic [ENTRY_W-1:0]    rd_bits;
  logic                  is_get;
  logic                  hit;
  logic [LEN_W-1:0]      clip;
  logic [SLOT_W+LEN_W-1:0] prod;
  trbi_pkg::out_item_t   res;

  assign out_free = !out_valid_r || out_ready;
  assign b_done   = b_busy_r && out_free;
  assign pop      = q_valid && (!b_busy_r || b_done);

  // slot store access for the popped command
  assign ram_we       = pop && (q_cmd.op == trbi_pkg::OP_PUT) && q_cmd.pre_ok;
  assign ram_en       = ram_we || (pop && (q_cmd.op == trbi_pkg::OP_GET));
  assign wr_entry.tc  = q_cmd.tc;
  assign wr_entry.len = q_cmd.len;

  trbi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (trbi_pkg::MAX_SLOTS)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (q_cmd.slot),
    .wdata (wr_entry),
    .rdata (rd_bits)
  );

  assign rd_entry = rd_bits;

  // result: timecode match, length clip and record offset
  assign is_get = (b_cmd_r.op == trbi_pkg::OP_GET);
  assign hit    = b_cmd_r.pre_ok && (!is_get || (rd_entry.tc == b_cmd_r.tc));
  assign clip   = (b_cmd_r.len < rd_entry.len) ? b_cmd_r.len : rd_entry.len;
  assign prod   = {{LEN_W{1'b0}}, b_cmd_r.slot} * {{SLOT_W{1'b0}}, record_bytes};

  always_comb begin
    res.ok              = hit;
    res.record_timecode = (is_get || hit) ? b_cmd_r.tc : '0;
    res.slot            = hit ? b_cmd_r.slot : '0;
    res.byte_offset     = hit ? prod[OFFSET_W-1:0] : '0;
    res.copy_length     = hit ? (is_get ? clip : b_cmd_r.len) : '0;
  end

  // busy flag and output register handshake
  always_comb begin
    b_busy_nxt = b_busy_r;
    if (pop) begin
      b_busy_nxt = 1'b1;
    end else if (b_done) begin
      b_busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (b_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_busy_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_busy_r    <= b_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_cmd_r <= q_cmd;
    end
    if (b_done) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a command whose result cannot leave stays in the back stage
  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    b_busy_r && !out_free |=> b_busy_r && $stable(b_cmd_r))
    else $error("back stage dropped a stalled command");

endmodule

[sv/timecoded_ring_buffer_index.sv]
// An accepted item goes through a queue entry and the back stage registers to its result in the output register.
// Throughput: one item per cycle while the output is ready; the back stage does at most one store access per item.
// The front updates the ring pointers as it accepts, so gets see earlier puts.
// Reset (synchronous, active low): ring empty, write slot zero, registers at defaults.
// Slot validity follows from the write-slot high mark, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// timecoded_ring_buffer_index
// Index engine for a ring of fixed-size frame records addressed by timecode.
// ----------------------------------------------------------------------------
module timecoded_ring_buffer_index #(
  parameter int QUEUE_DEPTH = trbi_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  trbi_stream_if.sink                       in_chan,
  trbi_stream_if.source                     out_chan,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [trbi_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [trbi_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [trbi_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int LEN_W   = trbi_pkg::LEN_W;
  localparam int COUNT_W = trbi_pkg::COUNT_W;
  localparam int DATA_W  = trbi_pkg::CFG_DATA_W;

  logic [LEN_W-1:0]   record_bytes_r, record_bytes_nxt;
  logic [COUNT_W-1:0] slot_count_r,   slot_count_nxt;

  trbi_pkg::reg_idx_t reg_idx;
  logic               cfg_write;
  logic [LEN_W:0]     rb_sum;
  logic [LEN_W:0]     rb_round;
  logic [LEN_W-1:0]   rb_value;

  logic               q_full;
  logic               q_push;
  trbi_pkg::cmd_t     q_push_cmd;
  logic               q_pop;
  logic               q_valid;
  trbi_pkg::cmd_t     q_head;

  // configuration registers
  assign pready    = 1'b1;
  assign reg_idx   = trbi_pkg::reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;

  // record size rounded up to the alignment, saturated at the largest size
  assign rb_sum   = {1'b0, pwdata[LEN_W-1:0]} + (LEN_W+1)'(trbi_pkg::ALIGN_BYTES - 1);
  assign rb_round = (rb_sum >> trbi_pkg::ALIGN_LOG2) << trbi_pkg::ALIGN_LOG2;
  assign rb_value = (rb_round > (LEN_W+1)'(trbi_pkg::REC_MAX)) ?
                    trbi_pkg::REC_MAX : rb_round[LEN_W-1:0];

  always_comb begin
    record_bytes_nxt = record_bytes_r;
    slot_count_nxt   = slot_count_r;
    if (cfg_write) begin
      case (reg_idx)
        trbi_pkg::REG_RECORD_BYTES: record_bytes_nxt = rb_value;
        trbi_pkg::REG_SLOT_COUNT:   slot_count_nxt   = pwdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_bytes_r <= LEN_W'(4096);
      slot_count_r   <= COUNT_W'(1024);
    end else begin
      record_bytes_r <= record_bytes_nxt;
      slot_count_r   <= slot_count_nxt;
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      trbi_pkg::REG_RECORD_BYTES: prdata = DATA_W'(record_bytes_r);
      trbi_pkg::REG_SLOT_COUNT:   prdata = DATA_W'(slot_count_r);
      default:                    prdata = '0;
    endcase
  end

  // front: accept and classify
  trbi_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_item    (in_chan.data),
    .in_ready   (in_chan.ready),
    .slot_count (slot_count_r),
    .q_full     (q_full),
    .push       (q_push),
    .cmd        (q_push_cmd)
  );

  trbi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  // back: store access and result
  trbi_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (q_head),
    .pop          (q_pop),
    .record_bytes (record_bytes_r),
    .out_valid    (out_chan.valid),
    .out_item     (out_chan.data),
    .out_ready    (out_chan.ready)
  );

endmodule
